/* rtl/epsc_pkg.sv */
// Shared constants, stage enable type and month table for the epoch-to-calendar pipeline.
`default_nettype none

package epsc_pkg;

    localparam int STAGES = 7;

    typedef logic [STAGES-1:0] stage_en_t;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [7:0]  YEAR_BIAS     = 8'd70;
    localparam logic [2:0]  EPOCH_WDAY    = 3'd4;
    localparam logic [8:0]  FEB29_DAY     = 9'd59;
    localparam logic [8:0]  LAST_LOOK_DAY = 9'd364;

    // Rounded-up reciprocals. Each quotient is exact over the operand range it sees.
    localparam logic [24:0] DAY_RECIP   = 25'd25451659;
    localparam int          DAY_SHIFT   = 34;
    localparam logic [15:0] YEAR_RECIP  = 16'd45965;
    localparam int          YEAR_SHIFT  = 24;
    localparam logic [15:0] WEEK_RECIP  = 16'd37450;
    localparam int          WEEK_SHIFT  = 18;
    localparam logic [16:0] HOUR_RECIP  = 17'd74566;
    localparam int          HOUR_SHIFT  = 24;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;
    localparam int          MIN_SHIFT   = 16;

    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] start;
        unique case (mon)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd59;
            4'd3:    start = 9'd90;
            4'd4:    start = 9'd120;
            4'd5:    start = 9'd151;
            4'd6:    start = 9'd181;
            4'd7:    start = 9'd212;
            4'd8:    start = 9'd243;
            4'd9:    start = 9'd273;
            4'd10:   start = 9'd304;
            4'd11:   start = 9'd334;
            default: start = 9'd365;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

/* rtl/epsc_day_split.sv */
// Stages one to three: day number, second of the day, weekday and year estimate.
`default_nettype none

module epsc_day_split (
    input  wire logic              clk,
    input  wire epsc_pkg::stage_en_t en,
    input  wire logic [30:0]       epoch_seconds,
    output logic [16:0]            sod,
    output logic [14:0]            day,
    output logic [14:0]            year_est,
    output logic [2:0]             wday
);
    import epsc_pkg::*;

    logic [30:0] s1_secs_reg;
    logic [48:0] s1_prod_reg;
    logic [48:0] s1_prod_next;

    logic [30:0] s2_secs_reg;
    logic [14:0] s2_day_reg;
    logic [30:0] s2_dprod_reg;
    logic [30:0] s2_yprod_reg;
    logic [30:0] s2_wprod_reg;
    logic [14:0] s2_day_next;
    logic [30:0] s2_dprod_next;
    logic [30:0] s2_yprod_next;
    logic [30:0] s2_wprod_next;
    logic [14:0] s2_wsum;

    logic [16:0] s3_sod_reg;
    logic [14:0] s3_day_reg;
    logic [14:0] s3_est_reg;
    logic [2:0]  s3_wday_reg;
    logic [16:0] s3_sod_next;
    logic [14:0] s3_est_next;
    logic [2:0]  s3_wday_next;
    logic [6:0]  years_est;
    logic [4:0]  q4;
    logic        c100;
    logic        c400;
    logic [14:0] wsum3;
    logic [12:0] wquot;

    assign s1_prod_next = 49'(epoch_seconds[30:7]) * 49'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_secs_reg <= epoch_seconds;
            s1_prod_reg <= s1_prod_next;
        end
    end

    always_comb
    begin
        s2_day_next   = s1_prod_reg[DAY_SHIFT+14:DAY_SHIFT];
        s2_wsum       = s2_day_next + 15'(EPOCH_WDAY);
        s2_dprod_next = 31'(32'(s2_day_next) * 32'(SECS_PER_DAY));
        s2_yprod_next = 31'(s2_day_next) * 31'(YEAR_RECIP);
        s2_wprod_next = 31'(s2_wsum) * 31'(WEEK_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_secs_reg  <= s1_secs_reg;
            s2_day_reg   <= s2_day_next;
            s2_dprod_reg <= s2_dprod_next;
            s2_yprod_reg <= s2_yprod_next;
            s2_wprod_reg <= s2_wprod_next;
        end
    end

    // The year estimate folds in the leap days counted from the rough year.
    always_comb
    begin
        s3_sod_next  = 17'(s2_secs_reg - s2_dprod_reg);
        wsum3        = s2_day_reg + 15'(EPOCH_WDAY);
        wquot        = s2_wprod_reg[WEEK_SHIFT+12:WEEK_SHIFT];
        s3_wday_next = 3'(wsum3 - 15'(wquot * 13'd7));
        years_est    = s2_yprod_reg[YEAR_SHIFT+6:YEAR_SHIFT];
        q4           = 5'((8'(years_est) + 8'd1) >> 2);
        c100         = (6'(q4) + 6'd17) >= 6'd25;
        c400         = 1'((3'(c100) + 3'd3) >> 2);
        s3_est_next  = s2_day_reg - 15'(q4) + 15'(c100) - 15'(c400);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_sod_reg  <= s3_sod_next;
            s3_day_reg  <= s2_day_reg;
            s3_est_reg  <= s3_est_next;
            s3_wday_reg <= s3_wday_next;
        end
    end

    assign sod      = s3_sod_reg;
    assign day      = s3_day_reg;
    assign year_est = s3_est_reg;
    assign wday     = s3_wday_reg;

endmodule

`default_nettype wire

/* rtl/epsc_clock.sv */
// Stages four to seven: hour, minute and second from the second of the day.
`default_nettype none

module epsc_clock (
    input  wire logic              clk,
    input  wire epsc_pkg::stage_en_t en,
    input  wire logic [16:0]       sod,
    output logic [5:0]             second,
    output logic [5:0]             minute,
    output logic [4:0]             hour
);
    import epsc_pkg::*;

    logic [29:0] s4_hprod_reg;
    logic [16:0] s4_sod_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_rem_reg;
    logic [4:0]  s5_hour_next;
    logic [11:0] s5_rem_next;
    logic [22:0] s6_mprod_reg;
    logic [11:0] s6_rem_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s7_sec_reg;
    logic [5:0]  s7_min_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_next;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_hprod_reg <= 30'(sod[16:4]) * 30'(HOUR_RECIP);
            s4_sod_reg   <= sod;
        end
    end

    always_comb
    begin
        s5_hour_next = s4_hprod_reg[HOUR_SHIFT+4:HOUR_SHIFT];
        s5_rem_next  = 12'(s4_sod_reg - 17'(17'(s5_hour_next) * 17'(SECS_PER_HOUR)));
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_hour_reg <= s5_hour_next;
            s5_rem_reg  <= s5_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_mprod_reg <= 23'(s5_rem_reg[11:2]) * 23'(MIN_RECIP);
            s6_rem_reg   <= s5_rem_reg;
            s6_hour_reg  <= s5_hour_reg;
        end
    end

    assign s7_min_next = s6_mprod_reg[MIN_SHIFT+5:MIN_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= 6'(s6_rem_reg - 12'(12'(s7_min_next) * 12'(SECS_PER_MIN)));
            s7_hour_reg <= s6_hour_reg;
        end
    end

    assign second = s7_sec_reg;
    assign minute = s7_min_reg;
    assign hour   = s7_hour_reg;

endmodule

`default_nettype wire

/* rtl/epsc_date.sv */
// Stages four to seven: year, day of the year, month and day of the month.
`default_nettype none

module epsc_date (
    input  wire logic              clk,
    input  wire epsc_pkg::stage_en_t en,
    input  wire logic [14:0]       day,
    input  wire logic [14:0]       year_est,
    input  wire logic [2:0]        wday,
    output logic [4:0]             month_day,
    output logic [3:0]             month,
    output logic [7:0]             years_since_1900,
    output logic [2:0]             week_day,
    output logic [8:0]             year_day
);
    import epsc_pkg::*;

    logic [30:0] s4_yprod_reg;
    logic [14:0] s4_day_reg;
    logic [2:0]  s4_wday_reg;

    logic [6:0]  s5_year_reg;
    logic [8:0]  s5_yday_reg;
    logic        s5_leap_reg;
    logic [2:0]  s5_wday_reg;
    logic [6:0]  s5_year_next;
    logic [8:0]  s5_yday_next;
    logic        s5_leap_next;
    logic [4:0]  lq;
    logic        lc;
    logic        lf;

    logic [8:0]  s6_look_reg;
    logic [8:0]  s6_dom_reg;
    logic [3:0]  s6_mon_reg;
    logic [6:0]  s6_year_reg;
    logic [8:0]  s6_yday_reg;
    logic [2:0]  s6_wday_reg;
    logic [8:0]  s6_look_next;
    logic [8:0]  s6_dom_next;

    logic [4:0]  s7_mday_reg;
    logic [3:0]  s7_mon_reg;
    logic [7:0]  s7_year_reg;
    logic [2:0]  s7_wday_reg;
    logic [8:0]  s7_yday_reg;
    logic [3:0]  s7_mon_next;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_yprod_reg <= 31'(year_est) * 31'(YEAR_RECIP);
            s4_day_reg   <= day;
            s4_wday_reg  <= wday;
        end
    end

    // Exact leap days before the year, and whether the year itself is a leap year.
    always_comb
    begin
        s5_year_next = s4_yprod_reg[YEAR_SHIFT+6:YEAR_SHIFT];
        lq           = 5'((8'(s5_year_next) + 8'd1) >> 2);
        lc           = (6'(lq) + 6'd17) >= 6'd25;
        lf           = 1'((3'(lc) + 3'd3) >> 2);
        s5_yday_next = 9'(s4_day_reg - 15'(lq) + 15'(lc) - 15'(lf)
                          - 15'(15'(s5_year_next) * 15'(DAYS_PER_YEAR)));
        s5_leap_next = ((s5_year_next - 7'({lq, 2'b00})) == 7'd2)
                       && (((8'(lq) - 8'(8'(lc) * 8'd25)) != 8'd7)
                           || ((3'(lc) - 3'({lf, 2'b00})) == 3'd0));
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_year_reg <= s5_year_next;
            s5_yday_reg <= s5_yday_next;
            s5_leap_reg <= s5_leap_next;
            s5_wday_reg <= s4_wday_reg;
        end
    end

    // In a leap year the month lookup runs one day behind from February 29 on.
    always_comb
    begin
        s6_look_next = s5_yday_reg;
        s6_dom_next  = s5_yday_reg;
        if (s5_leap_reg && (s5_yday_reg >= FEB29_DAY))
        begin
            s6_look_next = s5_yday_reg - 9'd1;
            if (s6_look_next >= FEB29_DAY)
            begin
                s6_dom_next = s5_yday_reg - 9'd1;
            end
        end
        if (s6_look_next > LAST_LOOK_DAY)
        begin
            s6_look_next = LAST_LOOK_DAY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_look_reg <= s6_look_next;
            s6_dom_reg  <= s6_dom_next;
            s6_mon_reg  <= s6_look_next[8:5];
            s6_year_reg <= s5_year_reg;
            s6_yday_reg <= s5_yday_reg;
            s6_wday_reg <= s5_wday_reg;
        end
    end

    assign s7_mon_next = s6_mon_reg
                         + 4'(month_start(s6_mon_reg + 4'd1) <= s6_look_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_mon_reg  <= s7_mon_next;
            s7_mday_reg <= 5'(s6_dom_reg - month_start(s7_mon_next) + 9'd1);
            s7_year_reg <= 8'(s6_year_reg) + YEAR_BIAS;
            s7_wday_reg <= s6_wday_reg;
            s7_yday_reg <= s6_yday_reg;
        end
    end

    assign month_day        = s7_mday_reg;
    assign month            = s7_mon_reg;
    assign years_since_1900 = s7_year_reg;
    assign week_day         = s7_wday_reg;
    assign year_day         = s7_yday_reg;

endmodule

`default_nettype wire

/* rtl/epoch_seconds_to_calendar.sv */
// Top level: seven-stage pipeline from seconds since 1970 to UTC calendar fields.
// An accepted input beat reaches the output after passing through every stage register in order.
// Throughput is one beat per cycle unless out_ready stalls; each stage holds one item and a bubble is filled at once.
// The depth is set by the chain of constant divisions: day, year, hour and minute.
// Reset clears the stage valid bits only; the data registers are not reset.
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [30:0] epoch_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       second,
    output logic [5:0]       minute,
    output logic [4:0]       hour,
    output logic [4:0]       month_day,
    output logic [3:0]       month,
    output logic [7:0]       years_since_1900,
    output logic [2:0]       week_day,
    output logic [8:0]       year_day
);
    import epsc_pkg::*;

    stage_en_t   adv;
    stage_en_t   valid_reg;
    stage_en_t   valid_next;
    logic [16:0] sod;
    logic [14:0] day;
    logic [14:0] year_est;
    logic [2:0]  wday;

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        for (int i = 0; i < STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];

    epsc_day_split u_day_split (
        .clk           (clk),
        .en            (adv),
        .epoch_seconds (epoch_seconds),
        .sod           (sod),
        .day           (day),
        .year_est      (year_est),
        .wday          (wday)
    );

    epsc_clock u_clock (
        .clk    (clk),
        .en     (adv),
        .sod    (sod),
        .second (second),
        .minute (minute),
        .hour   (hour)
    );

    epsc_date u_date (
        .clk              (clk),
        .en               (adv),
        .day              (day),
        .year_est         (year_est),
        .wday             (wday),
        .month_day        (month_day),
        .month            (month),
        .years_since_1900 (years_since_1900),
        .week_day         (week_day),
        .year_day         (year_day)
    );

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month < 4'd12) && (month_day != 5'd0) && (year_day < 9'd366)
                      && (week_day < 3'd7))
        else $error("calendar date out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (years_since_1900 >= 8'd70) && (years_since_1900 <= 8'd138))
        else $error("year out of range");

    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled while output side is ready");

endmodule

`default_nettype wire
